// ----- hdl/line_segment_screen_projection_unit_macros.svh -----
// Assertion helpers for the checker file of this block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef LINE_SEGMENT_SCREEN_PROJECTION_UNIT_MACROS_SVH
`define LINE_SEGMENT_SCREEN_PROJECTION_UNIT_MACROS_SVH

// The expression holds at every clock edge out of reset.
`define LSSP_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LSSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/lssp_pkg.sv -----
// ----------------------------------------------------------------------------
// Line segment screen projection package
// Shared widths, register indexes and payload types of the projection block.
// ----------------------------------------------------------------------------
package lssp_pkg;

  // Fixed-point formats.
  localparam int COORD_FRAC_BITS = 12;
  localparam int SUBPIXEL_BITS   = 4;

  // Field widths.
  localparam int COEF_W    = 16;
  localparam int COORD_W   = 24;
  localparam int SIZE_W    = 16;
  localparam int SCR_W     = 20;
  localparam int COLOR_W   = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  // Datapath widths.
  localparam int PROD_W     = COEF_W + COORD_W;
  localparam int CLIP_W     = PROD_W + 2;
  localparam int RW         = CLIP_W + 1;
  localparam int TW         = RW + 2;
  localparam int K_W        = SIZE_W + SUBPIXEL_BITS;
  localparam int DIV_STAGES = K_W + 1;
  localparam int V_W        = K_W + 3;

  // Pipeline depth: products, sums, band test, remainder setup, divider, output.
  localparam int FRONT_STAGES = 4;
  localparam int NUM_STAGES   = FRONT_STAGES + DIV_STAGES + 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATRIX_ROW_0  = 3'd0,
    REG_MATRIX_ROW_1  = 3'd1,
    REG_MATRIX_ROW_2  = 3'd2,
    REG_MATRIX_ROW_3  = 3'd3,
    REG_SCREEN_SIZE   = 3'd4,
    REG_SCREEN_OFFSET = 3'd5,
    REG_OUTPUT_ENABLE = 3'd6
  } cfg_reg_e;

  // Input segment.
  typedef struct packed {
    logic signed [COORD_W-1:0] point_a_x;
    logic signed [COORD_W-1:0] point_a_y;
    logic signed [COORD_W-1:0] point_a_z;
    logic signed [COORD_W-1:0] point_b_x;
    logic signed [COORD_W-1:0] point_b_y;
    logic signed [COORD_W-1:0] point_b_z;
    logic [COLOR_W-1:0]        line_color;
  } seg_in_t;

  // Projected segment.
  typedef struct packed {
    logic signed [SCR_W-1:0] screen_a_x;
    logic signed [SCR_W-1:0] screen_a_y;
    logic signed [SCR_W-1:0] screen_b_x;
    logic signed [SCR_W-1:0] screen_b_y;
    logic [COLOR_W-1:0]      segment_color;
  } seg_out_t;

  // One axis handed from a lane to its divider: integer part and remainder.
  typedef struct packed {
    logic signed [1:0] a;
    logic [RW-1:0]     r;
    logic [RW-1:0]     d;
  } axis_op_t;

endpackage

// ----- hdl/lssp_lane.sv -----
// ----------------------------------------------------------------------------
// Endpoint lane
// Transforms one endpoint to clip space, tests it against the guard band and
// splits each screen axis into an integer part and a remainder.
// ----------------------------------------------------------------------------
module lssp_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [lssp_pkg::FRONT_STAGES-1:0]   en_i,
  input  logic signed [lssp_pkg::COORD_W-1:0] x_i,
  input  logic signed [lssp_pkg::COORD_W-1:0] y_i,
  input  logic signed [lssp_pkg::COORD_W-1:0] z_i,
  input  logic [lssp_pkg::CFG_W-1:0]          row_x_i,
  input  logic [lssp_pkg::CFG_W-1:0]          row_y_i,
  input  logic [lssp_pkg::CFG_W-1:0]          row_w_i,
  output logic                                ok_o,
  output lssp_pkg::axis_op_t                  op_x_o,
  output lssp_pkg::axis_op_t                  op_y_o
);
  import lssp_pkg::*;

  logic [CFG_W-1:0]          rows [3];
  logic signed [COORD_W-1:0] pt [3];

  logic signed [PROD_W-1:0]  prod_q [3][3];
  logic signed [COEF_W-1:0]  coef3_q [3];
  logic signed [CLIP_W-1:0]  clip_q [3];
  logic signed [RW-1:0]      nx_q, ny_q, d_q;
  logic                      ok_q;
  axis_op_t                  op_x_q, op_y_q;

  logic signed [CLIP_W-1:0]  cx, cy, cw;
  logic                      ok_d;

  assign rows = '{row_x_i, row_y_i, row_w_i};
  assign pt   = '{x_i, y_i, z_i};

  // Normalized coordinate within 1.1 of center: 10*c in [-11*w, 11*w].
  function automatic logic in_band(logic signed [CLIP_W-1:0] c,
                                   logic signed [CLIP_W-1:0] w);
    logic signed [CLIP_W+4:0] c10;
    logic signed [CLIP_W+4:0] w11;
    c10 = (CLIP_W+5)'(c) * 10;
    w11 = (CLIP_W+5)'(w) * 11;
    return !((c10 < -w11) || (c10 > w11));
  endfunction

  // Split n/d into integer part in {-1, 0, 1} and remainder in [0, d).
  function automatic axis_op_t split(logic signed [RW-1:0] n, logic signed [RW-1:0] d);
    axis_op_t o;
    o.d = d;
    if (n < 0) begin
      o.a = -2'sd1;
      o.r = n + d;
    end else if (n >= d) begin
      o.a = 2'sd1;
      o.r = n - d;
    end else begin
      o.a = 2'sd0;
      o.r = n;
    end
    return o;
  endfunction

  // Products of the matrix entries with the coordinates.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= $signed(rows[r][COEF_W*c +: COEF_W]) * pt[c];
        end
        coef3_q[r] <= $signed(rows[r][COEF_W*3 +: COEF_W]);
      end
    end
  end

  // Clip components; the fourth coordinate is one.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int r = 0; r < 3; r++) begin
        clip_q[r] <= CLIP_W'(prod_q[r][0]) + CLIP_W'(prod_q[r][1]) + CLIP_W'(prod_q[r][2])
                   + (CLIP_W'(coef3_q[r]) <<< COORD_FRAC_BITS);
      end
    end
  end

  // Visibility test and numerators of the viewport mapping.
  assign cx   = clip_q[0];
  assign cy   = clip_q[1];
  assign cw   = clip_q[2];
  assign ok_d = (cw > 0) && in_band(cx, cw) && in_band(cy, cw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else if (en_i[2]) begin
      ok_q <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      nx_q <= RW'(cx) + RW'(cw);
      ny_q <= RW'(cw) - RW'(cy);
      d_q  <= RW'(cw) <<< 1;
    end
  end

  // Integer part and remainder of each axis.
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      op_x_q <= split(nx_q, d_q);
      op_y_q <= split(ny_q, d_q);
    end
  end

  assign ok_o   = ok_q;
  assign op_x_o = op_x_q;
  assign op_y_o = op_y_q;

endmodule

// ----- hdl/lssp_axis.sv -----
// ----------------------------------------------------------------------------
// Axis mapper
// Pipelined long division giving round(r*size*2^S/d), one quotient digit 0..2
// per stage, then offset, integer part and saturation in the output register.
// ----------------------------------------------------------------------------
module lssp_axis (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [lssp_pkg::DIV_STAGES:0]        en_i,
  input  lssp_pkg::axis_op_t                   op_i,
  input  logic [lssp_pkg::SIZE_W-1:0]          size_i,
  input  logic signed [lssp_pkg::SIZE_W-1:0]   off_i,
  output logic signed [lssp_pkg::SCR_W-1:0]    scr_o
);
  import lssp_pkg::*;

  localparam logic signed [SCR_W-1:0] ScrMax = {1'b0, {(SCR_W-1){1'b1}}};
  localparam logic signed [SCR_W-1:0] ScrMin = {1'b1, {(SCR_W-1){1'b0}}};

  logic [DIV_STAGES-1:0]     k2;
  logic [RW-1:0]             rem_q [DIV_STAGES];
  logic [DIV_STAGES-1:0]     q_q [DIV_STAGES];
  logic [RW-1:0]             r_q [DIV_STAGES];
  logic [RW-1:0]             d_q [DIV_STAGES];
  logic signed [1:0]         a_q [DIV_STAGES];
  logic signed [SCR_W-1:0]   scr_q;

  logic [DIV_STAGES:0]       qh;
  logic [K_W-1:0]            k;
  logic signed [V_W-1:0]     term_a;
  logic signed [V_W-1:0]     v;
  logic signed [V_W+SCR_W-1:0] vx;
  logic signed [SCR_W-1:0]   scr_d;

  // Twice the scaled size; bit i feeds the division stage of weight 2^i.
  assign k2 = {size_i, (SUBPIXEL_BITS+1)'(0)};
  assign k  = {size_i, SUBPIXEL_BITS'(0)};

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [RW-1:0]         rem_in, r_in, d_in, rem_out;
    logic [DIV_STAGES-1:0] q_in;
    logic signed [1:0]     a_in;
    logic [TW-1:0]         t, d1, d2;
    logic [1:0]            inc;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
      assign r_in   = op_i.r;
      assign d_in   = op_i.d;
      assign a_in   = op_i.a;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign q_in   = q_q[j-1];
      assign r_in   = r_q[j-1];
      assign d_in   = d_q[j-1];
      assign a_in   = a_q[j-1];
    end

    // Shift in the next multiplier bit, then take out d at most twice.
    always_comb begin
      d1 = TW'(d_in);
      d2 = {1'b0, d_in, 1'b0};
      t  = {1'b0, rem_in, 1'b0} + (k2[DIV_STAGES-1-j] ? TW'(r_in) : TW'(0));
      if (t >= d2) begin
        rem_out = RW'(t - d2);
        inc     = 2'd2;
      end else if (t >= d1) begin
        rem_out = RW'(t - d1);
        inc     = 2'd1;
      end else begin
        rem_out = RW'(t);
        inc     = 2'd0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= rem_out;
        q_q[j]   <= {q_in[DIV_STAGES-2:0], 1'b0} + DIV_STAGES'(inc);
        r_q[j]   <= r_in;
        d_q[j]   <= d_in;
        a_q[j]   <= a_in;
      end
    end
  end

  // Round half up, add integer part and offset, then saturate.
  always_comb begin
    qh = ({1'b0, q_q[DIV_STAGES-1]} + (DIV_STAGES+1)'(1)) >> 1;
    if (a_q[DIV_STAGES-1] == 2'sd1) begin
      term_a = V_W'({1'b0, k});
    end else if (a_q[DIV_STAGES-1] == -2'sd1) begin
      term_a = -V_W'({1'b0, k});
    end else begin
      term_a = '0;
    end
    v  = (V_W'(off_i) <<< SUBPIXEL_BITS) + term_a + V_W'(qh);
    vx = (V_W+SCR_W)'(v);
    if (vx > (V_W+SCR_W)'(ScrMax)) begin
      scr_d = ScrMax;
    end else if (vx < (V_W+SCR_W)'(ScrMin)) begin
      scr_d = ScrMin;
    end else begin
      scr_d = SCR_W'(vx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_q <= '0;
    end else if (en_i[DIV_STAGES]) begin
      scr_q <= scr_d;
    end
  end

  assign scr_o = scr_q;

endmodule

// ----- hdl/line_segment_screen_projection_unit.sv -----
// ----------------------------------------------------------------------------
// Line segment screen projection unit
// Two endpoint lanes and four axis dividers project a segment to the viewport.
// ----------------------------------------------------------------------------
// Stages from an input transfer to its result: 4 front stages, 21 divider
// stages of one quotient digit 0..2 each, one output register. Throughput: one
// segment per cycle unless stalled; each stage moves on when the next is free.
// Reset clears all valid bits and loads the identity matrix, a zero viewport
// and output enabled.
module line_segment_screen_projection_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lssp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lssp_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  lssp_pkg::seg_in_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output lssp_pkg::seg_out_t                out_data_o
);
  import lssp_pkg::*;

  localparam logic [CFG_W-1:0] MatrixReset [4] = '{
    64'h0000_0000_0000_0100, 64'h0000_0000_0100_0000,
    64'h0000_0100_0000_0000, 64'h0100_0000_0000_0000
  };

  logic [CFG_W-1:0]      matrix_q [4];
  logic [2*SIZE_W-1:0]   size_q;
  logic [2*SIZE_W-1:0]   offset_q;
  logic                  enable_q;

  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] en;
  logic [COLOR_W-1:0]    color_q [NUM_STAGES];

  logic                  ok_a, ok_b;
  axis_op_t              op_ax, op_ay, op_bx, op_by;
  logic signed [SCR_W-1:0] scr_ax, scr_ay, scr_bx, scr_by;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        matrix_q[i] <= MatrixReset[i];
      end
      size_q   <= '0;
      offset_q <= '0;
      enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_MATRIX_ROW_0:  matrix_q[0] <= cfg_data_i;
        REG_MATRIX_ROW_1:  matrix_q[1] <= cfg_data_i;
        REG_MATRIX_ROW_2:  matrix_q[2] <= cfg_data_i;
        REG_MATRIX_ROW_3:  matrix_q[3] <= cfg_data_i;
        REG_SCREEN_SIZE:   size_q      <= cfg_data_i[2*SIZE_W-1:0];
        REG_SCREEN_OFFSET: offset_q    <= cfg_data_i[2*SIZE_W-1:0];
        REG_OUTPUT_ENABLE: enable_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A stage loads when it or any stage after it is empty, or when the sink is ready.
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_en
    assign en[s] = out_ready_i | ~(&v_q[NUM_STAGES-1:s]);
  end

  // Valid bits; dropped segments leave a bubble after the band test.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        if (en[s]) begin
          if (s == 0) begin
            v_q[s] <= in_valid_i;
          end else if (s == FRONT_STAGES-1) begin
            v_q[s] <= v_q[s-1] & ok_a & ok_b & enable_q;
          end else begin
            v_q[s] <= v_q[s-1];
          end
        end
      end
    end
  end

  // Color travels alongside the datapath.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NUM_STAGES; s++) begin
      if (en[s]) begin
        color_q[s] <= (s == 0) ? in_data_i.line_color : color_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  // Endpoint lanes.
  lssp_lane u_lane_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[FRONT_STAGES-1:0]),
    .x_i     (in_data_i.point_a_x),
    .y_i     (in_data_i.point_a_y),
    .z_i     (in_data_i.point_a_z),
    .row_x_i (matrix_q[0]),
    .row_y_i (matrix_q[1]),
    .row_w_i (matrix_q[3]),
    .ok_o    (ok_a),
    .op_x_o  (op_ax),
    .op_y_o  (op_ay)
  );

  lssp_lane u_lane_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[FRONT_STAGES-1:0]),
    .x_i     (in_data_i.point_b_x),
    .y_i     (in_data_i.point_b_y),
    .z_i     (in_data_i.point_b_z),
    .row_x_i (matrix_q[0]),
    .row_y_i (matrix_q[1]),
    .row_w_i (matrix_q[3]),
    .ok_o    (ok_b),
    .op_x_o  (op_bx),
    .op_y_o  (op_by)
  );

  // Axis dividers: x uses the low halves of size and offset, y the high halves.
  lssp_axis u_axis_ax (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en[NUM_STAGES-1:FRONT_STAGES]),
    .op_i   (op_ax),
    .size_i (size_q[SIZE_W-1:0]),
    .off_i  ($signed(offset_q[SIZE_W-1:0])),
    .scr_o  (scr_ax)
  );

  lssp_axis u_axis_ay (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en[NUM_STAGES-1:FRONT_STAGES]),
    .op_i   (op_ay),
    .size_i (size_q[2*SIZE_W-1:SIZE_W]),
    .off_i  ($signed(offset_q[2*SIZE_W-1:SIZE_W])),
    .scr_o  (scr_ay)
  );

  lssp_axis u_axis_bx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en[NUM_STAGES-1:FRONT_STAGES]),
    .op_i   (op_bx),
    .size_i (size_q[SIZE_W-1:0]),
    .off_i  ($signed(offset_q[SIZE_W-1:0])),
    .scr_o  (scr_bx)
  );

  lssp_axis u_axis_by (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en[NUM_STAGES-1:FRONT_STAGES]),
    .op_i   (op_by),
    .size_i (size_q[2*SIZE_W-1:SIZE_W]),
    .off_i  ($signed(offset_q[2*SIZE_W-1:SIZE_W])),
    .scr_o  (scr_by)
  );

  // Merge the lane results into the outgoing transfer.
  assign out_data_o.screen_a_x    = scr_ax;
  assign out_data_o.screen_a_y    = scr_ay;
  assign out_data_o.screen_b_x    = scr_bx;
  assign out_data_o.screen_b_y    = scr_by;
  assign out_data_o.segment_color = color_q[NUM_STAGES-1];
  assign out_valid_o              = v_q[NUM_STAGES-1];
  assign in_ready_o               = en[0];

endmodule

// ----- hdl/lssp_checker.sv -----
// ----------------------------------------------------------------------------
// Projection unit port checker
// Watches the top-level ports for handshake and flow-control consistency.
// ----------------------------------------------------------------------------
`include "line_segment_screen_projection_unit_macros.svh"

module lssp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input lssp_pkg::seg_out_t             out_data_o
);

  // A waiting result stays offered.
  `LSSP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped before transfer")

  // A waiting result keeps its payload.
  `LSSP_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o), "result changed before transfer")

  // The input side only stalls when a result is blocked at the output.
  `LSSP_ASSERT_ALWAYS(a_stall_cause, clk_i, rst_ni, in_ready_o || (out_valid_o && !out_ready_i), "input stalled without output backpressure")

  // A ready sink always lets a new segment in.
  `LSSP_ASSERT_ALWAYS(a_ready_pass, clk_i, rst_ni, !out_ready_i || in_ready_o, "input stalled while output ready")

endmodule

bind line_segment_screen_projection_unit lssp_checker u_lssp_checker (.*);

// ----- bench/line_segment_screen_projection_unit_test.sv -----
// ----------------------------------------------------------------------------
// Line segment screen projection unit test
// Drives world-space segments through the projection block under random
// idling on both sides. Each segment is projected by a local fixed-point
// predictor, and every result transfer is checked in order, field by field.
// ----------------------------------------------------------------------------
module line_segment_screen_projection_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lssp_pkg::*;

  localparam int SCR_MAX = 524287;
  localparam int SCR_MIN = -524288;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  seg_in_t              in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  seg_out_t             out_data_o;

  // Predictor copy of the registers.
  logic [63:0] mat_row [4];
  logic [31:0] scr_size;
  logic [31:0] scr_offset;
  logic        proj_enable;

  seg_in_t  pending_segs [$];
  seg_out_t expected_segs [$];
  int       error_count;
  int       stall_cycles;
  bit       idle_free;
  bit       run_done;

  line_segment_screen_projection_unit dut (.*);

  // Clock.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Coefficient of the matrix at row r, column c.
  function automatic longint coef_at(int r, int c);
    return longint'($signed(mat_row[r][16*c +: 16]));
  endfunction

  function automatic longint clip_of(int r, longint px, longint py, longint pz);
    return coef_at(r, 0) * px + coef_at(r, 1) * py + coef_at(r, 2) * pz
         + coef_at(r, 3) * (longint'(1) <<< COORD_FRAC_BITS);
  endfunction

  function automatic bit in_guard_band(longint c, longint w);
    return !(10 * c < -11 * w || 10 * c > 11 * w);
  endfunction

  // Offset plus the rounded fraction n/d of the scaled viewport size.
  function automatic longint map_axis_px(longint n, longint d, longint size, longint off);
    longint a, r, k, q, rem, v;
    a = 0;
    if (n < 0) begin
      a = -1;
      r = n + d;
    end else begin
      a = n / d;
      r = n - a * d;
    end
    k = size <<< SUBPIXEL_BITS;
    q = (2 * k * r) / d;
    v = off * (longint'(1) <<< SUBPIXEL_BITS) + a * k + ((q + 1) >>> 1);
    if (v > SCR_MAX) v = SCR_MAX;
    if (v < SCR_MIN) v = SCR_MIN;
    return v;
  endfunction

  // Projects one endpoint; returns 0 when the endpoint is culled.
  function automatic bit project_point(longint px, longint py, longint pz,
                                       output longint sx, output longint sy);
    longint cx, cy, cw;
    cx = clip_of(0, px, py, pz);
    cy = clip_of(1, px, py, pz);
    cw = clip_of(3, px, py, pz);
    sx = 0;
    sy = 0;
    if (cw <= 0) return 1'b0;
    if (!in_guard_band(cx, cw) || !in_guard_band(cy, cw)) return 1'b0;
    sx = map_axis_px(cx + cw, 2 * cw, longint'(scr_size[15:0]),
                     longint'($signed(scr_offset[15:0])));
    sy = map_axis_px(cw - cy, 2 * cw, longint'(scr_size[31:16]),
                     longint'($signed(scr_offset[31:16])));
    return 1'b1;
  endfunction

  // Works out the projected segment, if any, for one accepted input.
  function automatic void predict_projection(seg_in_t s);
    longint ax, ay, bx, by;
    seg_out_t o;
    if (!proj_enable) return;
    if (!project_point(s.point_a_x, s.point_a_y, s.point_a_z, ax, ay)) return;
    if (!project_point(s.point_b_x, s.point_b_y, s.point_b_z, bx, by)) return;
    o.screen_a_x    = ax[19:0];
    o.screen_a_y    = ay[19:0];
    o.screen_b_x    = bx[19:0];
    o.screen_b_y    = by[19:0];
    o.segment_color = s.line_color;
    expected_segs.insert(expected_segs.size(), o);
  endfunction

  // Appends one segment to the pending queue.
  function automatic void enqueue_seg(seg_in_t s);
    pending_segs.insert(pending_segs.size(), s);
  endfunction

  // Driver: presents queued segments, idling at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_projection(in_data_i);
        void'(pending_segs.pop_front());
      end
      if (in_valid_i && !in_ready_o) begin
        // Hold the segment until its transfer.
      end else if (pending_segs.size() > 0
                   && (idle_free || $urandom_range(99) >= 26)) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_segs[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer and drives the result-side stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i  <= 1'b0;
      stall_cycles <= 0;
    end else begin
      out_ready_i <= idle_free || $urandom_range(99) >= 26;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (out_valid_o && out_ready_i) begin
        if (expected_segs.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $realtime, out_data_o);
          error_count++;
        end else begin
          seg_out_t e;
          e = expected_segs.pop_front();
          if (e.screen_a_x !== out_data_o.screen_a_x) begin
            $display("%0t: screen_a_x expected %0d actual %0d", $realtime,
                     e.screen_a_x, out_data_o.screen_a_x);
            error_count++;
          end
          if (e.screen_a_y !== out_data_o.screen_a_y) begin
            $display("%0t: screen_a_y expected %0d actual %0d", $realtime,
                     e.screen_a_y, out_data_o.screen_a_y);
            error_count++;
          end
          if (e.screen_b_x !== out_data_o.screen_b_x) begin
            $display("%0t: screen_b_x expected %0d actual %0d", $realtime,
                     e.screen_b_x, out_data_o.screen_b_x);
            error_count++;
          end
          if (e.screen_b_y !== out_data_o.screen_b_y) begin
            $display("%0t: screen_b_y expected %0d actual %0d", $realtime,
                     e.screen_b_y, out_data_o.screen_b_y);
            error_count++;
          end
          if (e.segment_color !== out_data_o.segment_color) begin
            $display("%0t: segment_color expected %h actual %h", $realtime,
                     e.segment_color, out_data_o.segment_color);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!run_done && stall_cycles >= WATCHDOG_LIMIT) begin
      $display("line_segment_screen_projection_unit_test: FAIL");
      $finish;
    end
  end

  // Writes one register and mirrors it in the predictor.
  task automatic write_reg(cfg_reg_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SCREEN_SIZE:   scr_size = val[31:0];
      REG_SCREEN_OFFSET: scr_offset = val[31:0];
      REG_OUTPUT_ENABLE: proj_enable = val[0];
      default:           mat_row[idx] = val;
    endcase
  endtask

  // Waits until every queued segment is sent and every result has come back.
  task automatic drain_block();
    while (pending_segs.size() != 0 || in_valid_i || expected_segs.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] q78(int v);
    return 16'(v);
  endfunction

  function automatic logic [63:0] mat_row_of(int c0, int c1, int c2, int c3);
    return {q78(c3), q78(c2), q78(c1), q78(c0)};
  endfunction

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(5))
      0:       return 24'($urandom);
      1:       return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($signed($urandom_range(16384)) - 8192);
    endcase
  endfunction

  function automatic seg_in_t rand_seg();
    seg_in_t s;
    s.point_a_x  = rand_coord();
    s.point_a_y  = rand_coord();
    s.point_a_z  = 24'($urandom);
    s.point_b_x  = rand_coord();
    s.point_b_y  = rand_coord();
    s.point_b_z  = 24'($urandom);
    s.line_color = $urandom;
    return s;
  endfunction

  function automatic seg_in_t make_seg(int ax, int ay, int bx, int by, logic [31:0] c);
    seg_in_t s;
    s.point_a_x  = 24'(ax);
    s.point_a_y  = 24'(ay);
    s.point_a_z  = 24'($urandom);
    s.point_b_x  = 24'(bx);
    s.point_b_y  = 24'(by);
    s.point_b_z  = 24'($urandom);
    s.line_color = c;
    return s;
  endfunction

  // Random perspective-like matrix with a positive w row.
  task automatic set_rand_matrix();
    write_reg(REG_MATRIX_ROW_0, mat_row_of($urandom_range(512) - 256,
              $urandom_range(64) - 32, $urandom_range(64) - 32, $urandom_range(512) - 256));
    write_reg(REG_MATRIX_ROW_1, mat_row_of($urandom_range(64) - 32,
              $urandom_range(512) - 256, $urandom_range(64) - 32, $urandom_range(512) - 256));
    write_reg(REG_MATRIX_ROW_2, {$urandom, $urandom});
    write_reg(REG_MATRIX_ROW_3, mat_row_of($urandom_range(32) - 16,
              $urandom_range(32) - 16, $urandom_range(64) - 32, $urandom_range(1024, 256)));
  endtask

  initial begin
    seg_in_t s;
    error_count = 0;
    run_done    = 1'b0;
    idle_free   = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    mat_row[0]  = 64'd256;
    mat_row[1]  = 64'd256 << 16;
    mat_row[2]  = 64'd256 << 32;
    mat_row[3]  = 64'd256 << 48;
    scr_size    = '0;
    scr_offset  = '0;
    proj_enable = 1'b1;
    rst_ni      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zero viewport gives the offset alone.
    enqueue_seg(make_seg(0, 0, 4096, -4096, 32'h11223344));
    enqueue_seg(make_seg(2048, 2048, -2048, -2048, 32'hFFFFFFFF));
    drain_block();

    // Directed: 1920 by 1080 viewport, the guard band edges and behind the eye.
    write_reg(REG_SCREEN_SIZE, {16'd1080, 16'd1920});
    write_reg(REG_SCREEN_OFFSET, {16'hFFF6, 16'd7});
    enqueue_seg(make_seg(4096, 4096, -4096, -4096, 32'h00000000));
    enqueue_seg(make_seg(4505, 0, 0, -4505, 32'hA5A5A5A5));
    enqueue_seg(make_seg(4506, 0, 0, 0, 32'h5A5A5A5A));
    enqueue_seg(make_seg(0, -4506, 0, 0, 32'h12345678));
    enqueue_seg(make_seg(1, -1, 4095, 3, 32'h87654321));
    enqueue_seg(make_seg(8388607, 0, 0, 0, 32'h0));
    enqueue_seg(make_seg(-8388608, -8388608, 0, 0, 32'h1));
    drain_block();
    write_reg(REG_MATRIX_ROW_3, mat_row_of(0, 0, 0, -256));
    enqueue_seg(make_seg(0, 0, 0, 0, 32'hDEADBEEF));
    drain_block();
    write_reg(REG_MATRIX_ROW_3, mat_row_of(256, 0, 0, 0));
    enqueue_seg(make_seg(0, 0, 4096, 0, 32'hCAFEF00D));
    drain_block();

    // Extremes: largest viewport and offsets saturate the output.
    write_reg(REG_MATRIX_ROW_3, mat_row_of(0, 0, 0, 256));
    write_reg(REG_SCREEN_SIZE, 64'hFFFF_FFFF);
    write_reg(REG_SCREEN_OFFSET, 64'h7FFF_7FFF);
    enqueue_seg(make_seg(4096, -4096, 0, 0, 32'hF0F0F0F0));
    drain_block();
    write_reg(REG_SCREEN_OFFSET, 64'h8000_8000);
    enqueue_seg(make_seg(-4096, 4096, 100, 100, 32'h0F0F0F0F));
    drain_block();
    write_reg(REG_MATRIX_ROW_0, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_MATRIX_ROW_1, 64'h8000_8000_8000_8000);
    write_reg(REG_MATRIX_ROW_3, 64'h7FFF_7FFF_7FFF_7FFF);
    for (int i = 0; i < 6; i++) enqueue_seg(rand_seg());
    drain_block();

    // Disabled: nothing comes out.
    write_reg(REG_OUTPUT_ENABLE, 64'd0);
    enqueue_seg(make_seg(0, 0, 0, 0, 32'h77777777));
    enqueue_seg(rand_seg());
    drain_block();
    write_reg(REG_OUTPUT_ENABLE, 64'd1);

    // Random phases over several settings.
    for (int ph = 0; ph < 10; ph++) begin
      set_rand_matrix();
      write_reg(REG_SCREEN_SIZE, ph == 9 ? 64'hFFFF_FFFF : 64'($urandom));
      write_reg(REG_SCREEN_OFFSET, 64'($urandom));
      write_reg(REG_OUTPUT_ENABLE, 64'(ph != 4));
      idle_free = (ph == 6);
      for (int i = 0; i < 72; i++) begin
        s = rand_seg();
        if ($urandom_range(3) != 0) begin
          // Mostly segments near the view center so they survive culling.
          s.point_a_x = 24'($signed($urandom_range(8192)) - 4096);
          s.point_a_y = 24'($signed($urandom_range(8192)) - 4096);
          s.point_b_x = 24'($signed($urandom_range(8192)) - 4096);
          s.point_b_y = 24'($signed($urandom_range(8192)) - 4096);
        end
        enqueue_seg(s);
      end
      drain_block();
    end

    run_done = 1'b1;
    if (error_count == 0)
      $display("line_segment_screen_projection_unit_test: PASS");
    else
      $display("line_segment_screen_projection_unit_test: FAIL");
    $finish;
  end
endmodule

// ----- line_segment_screen_projection_unit.f -----
+incdir+hdl
hdl/lssp_pkg.sv
hdl/lssp_lane.sv
hdl/lssp_axis.sv
hdl/line_segment_screen_projection_unit.sv
hdl/lssp_checker.sv
bench/line_segment_screen_projection_unit_test.sv
